// ----- rtl/ccl_pkg.sv -----
// Shared types, character codes, parse phase codes and field tables
// for the control command line parser. No dependencies.
package ccl_pkg;

  localparam int unsigned LINE_STORE_DEF = 64;
  localparam logic [9:0]  TOUCH_LIMIT_RST = 10'd480;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_T     = 8'h54;

  localparam logic [4:0] PH_START  = 5'd0;
  localparam logic [4:0] PH_E_LEAD = 5'd1;
  localparam logic [4:0] PH_B_LEAD = 5'd4;
  localparam logic [4:0] PH_T_LEAD = 5'd7;
  localparam logic [4:0] PH_TAIL_E = 5'd16;
  localparam logic [4:0] PH_TAIL_B = 5'd17;
  localparam logic [4:0] PH_TAIL_T = 5'd18;

  localparam logic [2:0] FLD_E  = 3'd0;
  localparam logic [2:0] FLD_B  = 3'd1;
  localparam logic [2:0] FLD_T1 = 3'd2;
  localparam logic [2:0] FLD_T2 = 3'd3;
  localparam logic [2:0] FLD_T3 = 3'd4;

  localparam logic [1:0] SUB_LEAD  = 2'd0;
  localparam logic [1:0] SUB_SIGN  = 2'd1;
  localparam logic [1:0] SUB_DIGIT = 2'd2;

  typedef enum logic [2:0] {
    KIND_ENC       = 3'd0,
    KIND_BTN       = 3'd1,
    KIND_TOUCH     = 3'd2,
    KIND_MALFORMED = 3'd3,
    KIND_TOO_LONG  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic signed [7:0] steps;
    logic              pressed;
    logic [9:0]        touch_x;
    logic [9:0]        touch_y;
  } res_t;

  typedef struct packed {
    logic [2:0] fld;
    logic [1:0] sub;
  } fld_t;

  function automatic fld_t phase_dec(input logic [4:0] ph);
    fld_t r;
    r = '0;
    case (ph) inside
      5'd1, 5'd2, 5'd3:    r.fld = FLD_E;
      5'd4, 5'd5, 5'd6:    r.fld = FLD_B;
      5'd7, 5'd8, 5'd9:    r.fld = FLD_T1;
      5'd10, 5'd11, 5'd12: r.fld = FLD_T2;
      5'd13, 5'd14, 5'd15: r.fld = FLD_T3;
      default:             r.fld = FLD_E;
    endcase
    case (ph) inside
      5'd2, 5'd5, 5'd8, 5'd11, 5'd14: r.sub = SUB_SIGN;
      5'd3, 5'd6, 5'd9, 5'd12, 5'd15: r.sub = SUB_DIGIT;
      default:                        r.sub = SUB_LEAD;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] fld_width(input logic [2:0] f);
    logic [2:0] w;
    unique case (f)
      FLD_E:          w = 3'd4;
      FLD_T2, FLD_T3: w = 3'd3;
      default:        w = 3'd1;
    endcase
    return w;
  endfunction

  function automatic logic [4:0] fld_next(input logic [2:0] f);
    logic [4:0] n;
    unique case (f)
      FLD_E:   n = PH_TAIL_E;
      FLD_B:   n = PH_TAIL_B;
      FLD_T1:  n = 5'd10;
      FLD_T2:  n = 5'd13;
      default: n = PH_TAIL_T;
    endcase
    return n;
  endfunction

  function automatic logic fin_fail(input logic [2:0] f, input logic neg,
                                    input logic [13:0] val);
    return ((f == FLD_T2) || (f == FLD_T3)) && neg && (val != 14'd0);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ----- rtl/control_command_line_parser.sv -----
// Control command line parser top level: line assembly, per-byte scanf-style
// parse and result delivery with a one-entry skid.
// Depends on ccl_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_stall_o/in_byte_i) takes one character beat
//   per cycle unless stalled. '!' opens a line, CR is skipped, LF closes it.
//   Output channel (out_valid_o / out_stall_i) delivers one result beat per
//   non-empty line: kind, steps, pressed, touch_x, touch_y.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i) writes the touch
//   limit; it is always ready. Write it only while the block is idle.
//   Throughput: one byte per cycle unless stalled. The parse state advances
//   in the cycle the byte is taken, through one decimal multiply-accumulate.
//   Result: registered from the LF beat into the output register or skid.
//   Stall: an output register plus a one-entry skid hold results; in_stall_o
//   is high only while the skid entry is occupied.
//   Reset: line closed, all parse state cleared, touch limit 480, both
//   result registers empty.
module control_command_line_parser
  import ccl_pkg::*;
#(
  parameter int unsigned LINE_STORE = LINE_STORE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        in_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        kind_o,
  output logic signed [7:0] steps_o,
  output logic              pressed_o,
  output logic [9:0]        touch_x_o,
  output logic [9:0]        touch_y_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [9:0]        cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(LINE_STORE);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LINE_STORE - 1);

  logic [9:0]       touch_limit_q;
  logic             collecting_q, collecting_d;
  logic             too_long_q, too_long_d;
  logic [CNT_W-1:0] char_cnt_q, char_cnt_d;
  logic [4:0]       phase_q, phase_d;
  logic [2:0]       dc_q, dc_d;
  logic             neg_q, neg_d;
  logic [13:0]      v1_q, v1_d;
  logic [9:0]       v2_q, v2_d;
  logic [9:0]       v3_q, v3_d;
  logic             ended_q, ended_d;
  logic             fail_q, fail_d;

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  res_t             out_q, skid_q, res;
  logic             res_go, accept, out_load;

  // Per-byte parse
  logic [4:0]  fd_phase, p0, e_phase;
  logic [2:0]  fd_dc, wr_f;
  logic        fd_neg, fd_fail, e_fail;
  logic [13:0] fd_v1, cur, acc, wr_val;
  logic [9:0]  fd_v2, fd_v3;
  logic [3:0]  dc_inc;
  logic        s0_go, tl_go, wr_en;
  fld_t        dec, dec0;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = skid_valid_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    dec = phase_dec(phase_q);
    case (dec.fld)
      FLD_T2:  cur = {4'd0, v2_q};
      FLD_T3:  cur = {4'd0, v3_q};
      default: cur = v1_q;
    endcase
    acc    = (cur << 3) + (cur << 1) + {10'd0, in_byte_i[3:0]};
    dc_inc = {1'b0, dc_q} + 4'd1;

    fd_phase = phase_q;
    fd_dc    = dc_q;
    fd_neg   = neg_q;
    fd_fail  = fail_q;
    wr_en    = 1'b0;
    wr_f     = dec.fld;
    wr_val   = cur;
    s0_go    = 1'b0;
    tl_go    = 1'b0;
    p0       = phase_q;

    if (phase_q == PH_START) begin
      case (in_byte_i)
        CH_E:    fd_phase = PH_E_LEAD;
        CH_B:    fd_phase = PH_B_LEAD;
        CH_T:    fd_phase = PH_T_LEAD;
        default: fd_fail = 1'b1;
      endcase
    end else if (phase_q >= PH_TAIL_E) begin
      tl_go = 1'b1;
    end else begin
      case (dec.sub)
        SUB_LEAD: s0_go = 1'b1;
        SUB_SIGN, SUB_DIGIT: begin
          if (is_digit(in_byte_i)) begin
            wr_en  = 1'b1;
            wr_val = (dec.sub == SUB_SIGN) ? {10'd0, in_byte_i[3:0]} : acc;
            fd_dc  = dc_inc[2:0];
            if (dc_inc >= {1'b0, fld_width(dec.fld)}) begin
              fd_phase = fld_next(dec.fld);
              if (fin_fail(dec.fld, neg_q, wr_val)) fd_fail = 1'b1;
            end else begin
              fd_phase = (dec.sub == SUB_SIGN) ? phase_q + 5'd1 : phase_q;
            end
          end else if (dec.sub == SUB_SIGN) begin
            fd_fail = 1'b1;
          end else begin
            // close the number, then reparse this byte in the next phase
            fd_phase = fld_next(dec.fld);
            if (fin_fail(dec.fld, neg_q, cur)) begin
              fd_fail = 1'b1;
            end else begin
              p0 = fld_next(dec.fld);
              if (p0 >= PH_TAIL_E) tl_go = 1'b1;
              else s0_go = 1'b1;
            end
          end
        end
        default: fd_fail = 1'b1;
      endcase
    end

    if (tl_go && !is_ws(in_byte_i)) fd_fail = 1'b1;

    dec0 = phase_dec(p0);
    if (s0_go && !is_ws(in_byte_i)) begin
      if (in_byte_i == CH_PLUS || in_byte_i == CH_MINUS) begin
        fd_neg = (in_byte_i == CH_MINUS);
        fd_dc  = 3'd1;
        wr_en  = 1'b1;
        wr_f   = dec0.fld;
        wr_val = 14'd0;
        if (fld_width(dec0.fld) <= 3'd1) fd_fail = 1'b1;
        else fd_phase = p0 + 5'd1;
      end else if (is_digit(in_byte_i)) begin
        fd_neg = 1'b0;
        fd_dc  = 3'd1;
        wr_en  = 1'b1;
        wr_f   = dec0.fld;
        wr_val = {10'd0, in_byte_i[3:0]};
        if (fld_width(dec0.fld) <= 3'd1) fd_phase = fld_next(dec0.fld);
        else fd_phase = p0 + 5'd2;
      end else begin
        fd_fail = 1'b1;
      end
    end

    fd_v1 = v1_q;
    fd_v2 = v2_q;
    fd_v3 = v3_q;
    if (wr_en) begin
      case (wr_f)
        FLD_T2:  fd_v2 = wr_val[9:0];
        FLD_T3:  fd_v3 = wr_val[9:0];
        default: fd_v1 = wr_val;
      endcase
    end
  end

  // Line end evaluation
  always_comb begin
    e_phase = phase_q;
    e_fail  = fail_q;
    if (!fail_q && phase_q != PH_START && phase_q < PH_TAIL_E &&
        dec.sub == SUB_DIGIT) begin
      e_phase = fld_next(dec.fld);
      if (fin_fail(dec.fld, neg_q, cur)) e_fail = 1'b1;
    end

    res         = '0;
    res.kind    = KIND_MALFORMED;
    if (too_long_q) begin
      res.kind = KIND_TOO_LONG;
    end else if (!e_fail) begin
      if (e_phase == PH_TAIL_E && v1_q >= 14'd1 && v1_q <= 14'd127) begin
        res.kind  = KIND_ENC;
        res.steps = neg_q ? $signed(~v1_q[7:0] + 8'd1) : $signed(v1_q[7:0]);
      end else if (e_phase == PH_TAIL_B && v1_q <= 14'd1) begin
        res.kind    = KIND_BTN;
        res.pressed = v1_q[0];
      end else if (e_phase == PH_TAIL_T && v1_q <= 14'd1 &&
                   v2_q < touch_limit_q && v3_q < touch_limit_q) begin
        res.kind    = KIND_TOUCH;
        res.pressed = v1_q[0];
        res.touch_x = v2_q;
        res.touch_y = v3_q;
      end
    end
  end

  // Line control
  always_comb begin
    collecting_d = collecting_q;
    too_long_d   = too_long_q;
    char_cnt_d   = char_cnt_q;
    phase_d      = phase_q;
    dc_d         = dc_q;
    neg_d        = neg_q;
    v1_d         = v1_q;
    v2_d         = v2_q;
    v3_d         = v3_q;
    ended_d      = ended_q;
    fail_d       = fail_q;
    res_go       = 1'b0;

    if (accept && (in_byte_i == CH_BANG ||
                   (collecting_q && in_byte_i == CH_LF))) begin
      res_go       = (in_byte_i == CH_LF) && (too_long_q || char_cnt_q != '0);
      collecting_d = (in_byte_i == CH_BANG);
      too_long_d   = 1'b0;
      char_cnt_d   = '0;
      phase_d      = PH_START;
      dc_d         = 3'd0;
      neg_d        = 1'b0;
      v1_d         = 14'd0;
      v2_d         = 10'd0;
      v3_d         = 10'd0;
      ended_d      = 1'b0;
      fail_d       = 1'b0;
    end else if (accept && collecting_q && in_byte_i != CH_CR && !too_long_q) begin
      if (char_cnt_q < CNT_MAX) begin
        char_cnt_d = char_cnt_q + 1'b1;
        if (!ended_q) begin
          if (in_byte_i == CH_NUL) begin
            ended_d = 1'b1;
          end else if (!fail_q) begin
            phase_d = fd_phase;
            dc_d    = fd_dc;
            neg_d   = fd_neg;
            v1_d    = fd_v1;
            v2_d    = fd_v2;
            v3_d    = fd_v3;
            fail_d  = fd_fail;
          end
        end
      end else begin
        too_long_d = 1'b1;
      end
    end
  end

  assign out_load     = !out_valid_q || !out_stall_i;
  assign out_valid_d  = out_load ? (skid_valid_q || res_go) : 1'b1;
  assign skid_valid_d = out_load ? 1'b0 : (skid_valid_q || res_go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      touch_limit_q <= TOUCH_LIMIT_RST;
      collecting_q  <= 1'b0;
      too_long_q    <= 1'b0;
      char_cnt_q    <= '0;
      phase_q       <= PH_START;
      dc_q          <= 3'd0;
      neg_q         <= 1'b0;
      v1_q          <= 14'd0;
      v2_q          <= 10'd0;
      v3_q          <= 10'd0;
      ended_q       <= 1'b0;
      fail_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) touch_limit_q <= cfg_data_i;
      collecting_q <= collecting_d;
      too_long_q   <= too_long_d;
      char_cnt_q   <= char_cnt_d;
      phase_q      <= phase_d;
      dc_q         <= dc_d;
      neg_q        <= neg_d;
      v1_q         <= v1_d;
      v2_q         <= v2_d;
      v3_q         <= v3_d;
      ended_q      <= ended_d;
      fail_q       <= fail_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_go) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = out_q.kind;
  assign steps_o     = out_q.steps;
  assign pressed_o   = out_q.pressed;
  assign touch_x_o   = out_q.touch_x;
  assign touch_y_o   = out_q.touch_y;

  ast_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  ast_closed_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !collecting_q |-> (char_cnt_q == '0) && !too_long_q && (phase_q == PH_START))
    else $error("line state not cleared while no line is open");

  ast_too_long_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    too_long_q |-> (char_cnt_q == CNT_MAX))
    else $error("overlength flag set before the line store filled");

  ast_bang_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_byte_i == CH_BANG) |=> collecting_q && (char_cnt_q == '0) && !fail_q)
    else $error("start byte did not open a fresh line");

endmodule

// ----- tb/control_command_line_parser_test.sv -----
// Self-checking testbench for control_command_line_parser: a table of directed
// command lines, then random line traffic under several touch limits.
// Depends on ccl_pkg and the parser RTL.
module control_command_line_parser_test;
  import ccl_pkg::*;

  typedef struct {
    string       text;
    int unsigned fill;
    bit          typed;
    res_t        want;
  } row_t;

  localparam res_t BAD_LINE = '{KIND_MALFORMED, 8'sd0, 1'b0, 10'd0, 10'd0};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_byte;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        kind;
  logic signed [7:0] steps;
  logic              pressed;
  logic [9:0]        touch_x;
  logic [9:0]        touch_y;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [9:0]        cfg_data;

  res_t        pending_results[$];
  int unsigned mismatches = 0;
  int unsigned stall_left = 0;
  bit          calm = 1'b0;
  bit          use_typed = 1'b0;
  res_t        typed_res;
  logic [7:0]  line_q[$];

  logic [9:0]  limit_model;
  bit          line_open;
  bit          overlong;
  bit          text_stopped;
  bit          scan_failed;
  bit          minus_seen;
  int unsigned kept_bytes;
  int unsigned scan_phase;
  int unsigned num_chars;
  logic [13:0] field_val[3];

  // ~ marks a zero byte; fill pads spaces ahead of the last byte of a row
  row_t rows[26] = '{
    '{"!E 127\n", 0, 1'b1, '{KIND_ENC, 8'sd127, 1'b0, 10'd0, 10'd0}},
    '{"!E -127\n", 0, 1'b1, '{KIND_ENC, -8'sd127, 1'b0, 10'd0, 10'd0}},
    '{"!E 0\n", 0, 1'b1, BAD_LINE},
    '{"!E 9999\n", 0, 1'b1, BAD_LINE},
    '{"!E 12\r\n", 0, 1'b0, '0},
    '{"!E +0127\n", 0, 1'b0, '0},
    '{"!E -\n", 0, 1'b1, BAD_LINE},
    '{"!B 1\n", 0, 1'b1, '{KIND_BTN, 8'sd0, 1'b1, 10'd0, 10'd0}},
    '{"!B\t0\r\n", 0, 1'b1, '{KIND_BTN, 8'sd0, 1'b0, 10'd0, 10'd0}},
    '{"!B 2\n", 0, 1'b1, BAD_LINE},
    '{"!B +1\n", 0, 1'b1, BAD_LINE},
    '{"!T 1 479 479\n", 0, 1'b1, '{KIND_TOUCH, 8'sd0, 1'b1, 10'd479, 10'd479}},
    '{"!T 0 0 0\n", 0, 1'b1, '{KIND_TOUCH, 8'sd0, 1'b0, 10'd0, 10'd0}},
    '{"!T 1 480 0\n", 0, 1'b1, BAD_LINE},
    '{"!T1123456\n", 0, 1'b0, '0},
    '{"!T 0 -0 -0\n", 0, 1'b1, '{KIND_TOUCH, 8'sd0, 1'b0, 10'd0, 10'd0}},
    '{"!T 0 -1 5\n", 0, 1'b1, BAD_LINE},
    '{"!E 5 x\n", 0, 1'b1, BAD_LINE},
    '{"!E 5 \v\f\n", 0, 1'b0, '0},
    '{"!E 5~junk\n", 0, 1'b0, '0},
    '{"\nQ!\n", 0, 1'b0, '0},
    '{"!E 9!B 1\n", 0, 1'b0, '0},
    '{"!\377\n", 0, 1'b1, BAD_LINE},
    '{"!E 1\n", 60, 1'b1, '{KIND_ENC, 8'sd1, 1'b0, 10'd0, 10'd0}},
    '{"!E 1\n", 61, 1'b1, '{KIND_TOO_LONG, 8'sd0, 1'b0, 10'd0, 10'd0}},
    '{"!+\n", 0, 1'b0, '0}
  };

  control_command_line_parser DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_byte_i   (in_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .kind_o      (kind),
    .steps_o     (steps),
    .pressed_o   (pressed),
    .touch_x_o   (touch_x),
    .touch_y_o   (touch_y),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  function automatic int unsigned phase_of(int unsigned f, int unsigned s);
    return 1 + 3 * f + s;
  endfunction

  function automatic int unsigned field_digits(int unsigned f);
    case (f)
      FLD_E:          return 4;
      FLD_T2, FLD_T3: return 3;
      default:        return 1;
    endcase
  endfunction

  function automatic int unsigned field_slot(int unsigned f);
    case (f)
      FLD_T2:  return 1;
      FLD_T3:  return 2;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned field_after(int unsigned f);
    case (f)
      FLD_E:   return PH_TAIL_E;
      FLD_B:   return PH_TAIL_B;
      FLD_T1:  return phase_of(FLD_T2, SUB_LEAD);
      FLD_T2:  return phase_of(FLD_T3, SUB_LEAD);
      default: return PH_TAIL_T;
    endcase
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_VT, CH_FF};
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void clear_scan();
    overlong = 1'b0;
    kept_bytes = 0;
    scan_phase = PH_START;
    num_chars = 0;
    minus_seen = 1'b0;
    foreach (field_val[i]) field_val[i] = '0;
    text_stopped = 1'b0;
    scan_failed = 1'b0;
  endfunction

  function automatic void close_field(int unsigned f);
    if ((f == FLD_T2 || f == FLD_T3) && minus_seen && field_val[field_slot(f)] != 0)
      scan_failed = 1'b1;
    scan_phase = field_after(f);
  endfunction

  function automatic void scan_char(logic [7:0] c);
    int unsigned f;
    int unsigned s;
    int unsigned k;
    bit again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      if (scan_phase == PH_START) begin
        if (c == CH_E) scan_phase = PH_E_LEAD;
        else if (c == CH_B) scan_phase = PH_B_LEAD;
        else if (c == CH_T) scan_phase = PH_T_LEAD;
        else scan_failed = 1'b1;
      end else if (scan_phase >= PH_TAIL_E) begin
        if (!blank(c)) scan_failed = 1'b1;
      end else begin
        f = (scan_phase - 1) / 3;
        s = (scan_phase - 1) % 3;
        k = field_slot(f);
        if (s == SUB_LEAD) begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            minus_seen = (c == CH_MINUS);
            num_chars = 1;
            field_val[k] = '0;
            if (field_digits(f) <= 1) scan_failed = 1'b1;
            else scan_phase = phase_of(f, SUB_SIGN);
          end else if (digit(c)) begin
            minus_seen = 1'b0;
            num_chars = 1;
            field_val[k] = 14'(c - CH_ZERO);
            if (num_chars >= field_digits(f)) close_field(f);
            else scan_phase = phase_of(f, SUB_DIGIT);
          end else if (!blank(c)) begin
            scan_failed = 1'b1;
          end
        end else if (s == SUB_SIGN) begin
          if (digit(c)) begin
            field_val[k] = 14'(c - CH_ZERO);
            num_chars++;
            if (num_chars >= field_digits(f)) close_field(f);
            else scan_phase = phase_of(f, SUB_DIGIT);
          end else begin
            scan_failed = 1'b1;
          end
        end else if (digit(c)) begin
          field_val[k] = field_val[k] * 14'd10 + 14'(c - CH_ZERO);
          num_chars++;
          if (num_chars >= field_digits(f)) close_field(f);
        end else begin
          close_field(f);
          again = !scan_failed;
        end
      end
    end
  endfunction

  function automatic res_t close_line();
    res_t r;
    r = BAD_LINE;
    if (overlong) begin
      r.kind = KIND_TOO_LONG;
      return r;
    end
    if (!scan_failed && scan_phase >= PH_E_LEAD && scan_phase < PH_TAIL_E &&
        (scan_phase - 1) % 3 == SUB_DIGIT)
      close_field((scan_phase - 1) / 3);
    if (scan_failed) return r;
    if (scan_phase == PH_TAIL_E && field_val[0] >= 1 && field_val[0] <= 127) begin
      r.kind = KIND_ENC;
      r.steps = minus_seen ? -8'(field_val[0]) : 8'(field_val[0]);
    end else if (scan_phase == PH_TAIL_B && field_val[0] <= 1) begin
      r.kind = KIND_BTN;
      r.pressed = field_val[0][0];
    end else if (scan_phase == PH_TAIL_T && field_val[0] <= 1 &&
                 field_val[1] < limit_model && field_val[2] < limit_model) begin
      r.kind = KIND_TOUCH;
      r.pressed = field_val[0][0];
      r.touch_x = field_val[1][9:0];
      r.touch_y = field_val[2][9:0];
    end
    return r;
  endfunction

  function automatic bit predict_command_byte(logic [7:0] b, output res_t r);
    bit got;
    r = BAD_LINE;
    if (b == CH_BANG) begin
      line_open = 1'b1;
      clear_scan();
      return 1'b0;
    end
    if (!line_open || b == CH_CR) return 1'b0;
    if (b == CH_LF) begin
      got = overlong || kept_bytes > 0;
      if (got) r = close_line();
      line_open = 1'b0;
      clear_scan();
      return got;
    end
    if (!overlong) begin
      if (kept_bytes < LINE_STORE_DEF - 1) begin
        kept_bytes++;
        if (!text_stopped) begin
          if (b == CH_NUL) text_stopped = 1'b1;
          else if (!scan_failed) scan_char(b);
        end
      end else begin
        overlong = 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void put_blank(int unsigned most);
    logic [7:0] ws[4];
    ws = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
    repeat ($urandom_range(most, 0)) line_q.push_back(ws[$urandom_range(3, 0)]);
  endfunction

  function automatic void put_num(int unsigned sign_pct, int unsigned lo, int unsigned hi);
    string s;
    if ($urandom_range(99, 0) < sign_pct)
      line_q.push_back($urandom_range(2, 0) == 0 ? CH_PLUS : CH_MINUS);
    if ($urandom_range(9, 0) == 0) line_q.push_back(CH_ZERO);
    s = $sformatf("%0d", $urandom_range(hi, lo));
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void put_coord();
    int unsigned hi;
    hi = limit_model > 999 ? 999 : limit_model;
    if ($urandom_range(3, 0) == 0) put_num(8, hi > 0 ? hi - 1 : 0, hi);
    else put_num(8, 0, 999);
  endfunction

  function automatic void make_line();
    int unsigned pick;
    int unsigned body;
    line_q.delete();
    if ($urandom_range(9, 0) == 0)
      repeat ($urandom_range(3, 1)) line_q.push_back(8'($urandom_range(255, 0)));
    line_q.push_back(CH_BANG);
    body = line_q.size();
    pick = $urandom_range(99, 0);
    if (pick < 25) begin
      line_q.push_back(CH_E);
      put_blank(2);
      put_num(40, 0, $urandom_range(4, 0) == 0 ? 9999 : 140);
    end else if (pick < 45) begin
      line_q.push_back(CH_B);
      put_blank(2);
      put_num(10, 0, $urandom_range(4, 0) == 0 ? 9 : 1);
    end else if (pick < 75) begin
      line_q.push_back(CH_T);
      put_blank(2);
      put_num(5, 0, $urandom_range(4, 0) == 0 ? 9 : 1);
      put_blank(2);
      put_coord();
      put_blank(2);
      put_coord();
    end else if (pick < 82) begin
      repeat ($urandom_range(12, 0)) line_q.push_back(8'($urandom_range(255, 0)));
    end else if (pick < 88) begin
      repeat ($urandom_range(70, 60)) line_q.push_back(8'($urandom_range(8'h7E, 8'h22)));
    end
    if (pick < 75) begin
      put_blank(2);
      pick = $urandom_range(99, 0);
      if (pick < 10) begin
        line_q.push_back(8'($urandom_range(8'h7E, 8'h22)));
      end else if (pick < 18) begin
        line_q.push_back(CH_NUL);
        repeat ($urandom_range(4, 0)) line_q.push_back(8'($urandom_range(255, 0)));
      end else if (pick < 26) begin
        repeat ($urandom_range(line_q.size() - body, 1)) void'(line_q.pop_back());
      end else if (pick < 31) begin
        line_q[$urandom_range(line_q.size() - 1, body)] = 8'($urandom_range(255, 0));
      end
    end
    if ($urandom_range(4, 0) == 0) line_q.push_back(CH_CR);
    line_q.push_back(CH_LF);
  endfunction

  task automatic report_bad(string what);
    mismatches++;
    $display("%0t: %s", $time, what);
  endtask

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    res_t r;
    gap = calm ? 0 : $urandom_range(5, 0);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    if (predict_command_byte(b, r)) pending_results.push_back(use_typed ? typed_res : r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(logic [9:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    limit_model = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watch_results
    res_t w;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        stall_left = calm ? 0 : $urandom_range(5, 0);
        if (pending_results.size() == 0) begin
          report_bad("result beat with nothing expected");
        end else begin
          w = pending_results.pop_front();
          if (kind !== w.kind)
            report_bad($sformatf("kind %0d, expected %0d", kind, w.kind));
          if (steps !== w.steps)
            report_bad($sformatf("steps %0d, expected %0d", steps, w.steps));
          if (pressed !== w.pressed)
            report_bad($sformatf("pressed %0d, expected %0d", pressed, w.pressed));
          if (touch_x !== w.touch_x)
            report_bad($sformatf("touch_x %0d, expected %0d", touch_x, w.touch_x));
          if (touch_y !== w.touch_y)
            report_bad($sformatf("touch_y %0d, expected %0d", touch_y, w.touch_y));
        end
      end
      @(negedge clk);
      if (out_valid && stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned sent;
    bit held;
    logic [9:0] limits[6];
    in_valid = 1'b0;
    in_byte = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    rst_n = 1'b0;
    limit_model = TOUCH_LIMIT_RST;
    line_open = 1'b0;
    clear_scan();
    limits = '{10'd1023, 10'd0, 10'd1, 10'd999, TOUCH_LIMIT_RST, 10'd0};
    limits[5] = 10'($urandom_range(998, 2));
    sent = 0;
    held = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      use_typed = rows[i].typed;
      typed_res = rows[i].want;
      for (int j = 0; j < rows[i].text.len(); j++) begin
        if (j == rows[i].text.len() - 1) repeat (rows[i].fill) send_byte(CH_SPACE);
        send_byte(rows[i].text[j] == "~" ? CH_NUL : rows[i].text[j]);
      end
    end
    use_typed = 1'b0;

    foreach (limits[p]) begin
      drain();
      write_limit(limits[p]);
      calm = (p == 2);
      while (sent < 205 * (p + 1)) begin
        make_line();
        foreach (line_q[i]) send_byte(line_q[i]);
        sent += line_q.size();
        // hold the sender once until every result is back
        if (p == 0 && !held && sent > 130) begin
          drain();
          held = 1'b1;
        end
        if (p != 2 && $urandom_range(19, 0) == 0) calm = !calm;
      end
    end

    drain();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ccl_pkg.sv
rtl/control_command_line_parser.sv
tb/control_command_line_parser_test.sv
